// ===== hdl/hbomc_pkg.sv =====
package hbomc_pkg;

    localparam int PWM_BITS = 12;
    localparam int LEVEL_W  = PWM_BITS + 1;
    localparam int DUTY_W   = 14;
    localparam int CALC_W   = DUTY_W + 1;
    localparam int TICK_W   = 16;

    localparam logic [CALC_W-1:0] FULL_SCALE = CALC_W'(1 << PWM_BITS);
    localparam logic [CALC_W-1:0] LEVEL_MAX  = FULL_SCALE - CALC_W'(1);

    // Reset values of the configuration registers.
    localparam logic [TICK_W-1:0] INHIBIT_TICKS_RST = 16'd1000;
    localparam logic [TICK_W-1:0] ALIVE_TICKS_RST   = 16'd3000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INHIBIT_TICKS       = 2'd0;
    localparam logic [1:0] CFG_ALIVE_TICKS         = 2'd1;
    localparam logic [1:0] CFG_STOP_ENTERS_INHIBIT = 2'd2;

    // Mode codes as they appear on the result.
    localparam logic [1:0] CODE_OFF     = 2'd0;
    localparam logic [1:0] CODE_ON      = 2'd1;
    localparam logic [1:0] CODE_INHIBIT = 2'd2;
    localparam logic [1:0] CODE_FAULT   = 2'd3;

    localparam logic ACTION_TICK    = 1'b0;
    localparam logic ACTION_COMMAND = 1'b1;

    typedef enum logic [3:0] {
        MODE_OFF     = 4'b0001,
        MODE_ON      = 4'b0010,
        MODE_INHIBIT = 4'b0100,
        MODE_FAULT   = 4'b1000
    } mode_t;

    typedef struct packed {
        logic       action;
        logic [7:0] cmd_low;
        logic [7:0] cmd_high;
        logic       fault_active;
    } in_t;

    typedef struct packed {
        logic [1:0]         mode_now;
        logic               dir_forward;
        logic               dir_reverse;
        logic               external_control;
        logic               over_current_flag;
        logic [DUTY_W-1:0]  duty_setting;
        logic [LEVEL_W-1:0] pwm_one_level;
        logic [LEVEL_W-1:0] pwm_two_level;
    } out_t;

endpackage

// ===== hdl/hbridge_output_mode_controller_unit.sv =====
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid / in_ready     | in_data  (hbomc_pkg::in_t)
// out     | output    | out_valid / out_ready   | out_data (hbomc_pkg::out_t)
// cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item per cycle while the result is not stalled: a transaction is captured in
// the input register, then the mode logic writes the state and the result register
// from it once the result register is free or being taken.
// Reset clears state and valid flags and restores config defaults at once.
// A stalled result holds the pipeline; the input register still accepts one
// transaction while the result waits. cfg_ready is always high.
module hbridge_output_mode_controller_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  hbomc_pkg::in_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output hbomc_pkg::out_t out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    typedef struct packed {
        hbomc_pkg::mode_t                     mode;
        logic                                 fwd;
        logic                                 rvs;
        logic                                 ext;
        logic                                 oc;
        logic [hbomc_pkg::DUTY_W-1:0]         duty;
        logic [hbomc_pkg::LEVEL_W-1:0]        pwm_one;
        logic [hbomc_pkg::LEVEL_W-1:0]        pwm_two;
        logic [hbomc_pkg::TICK_W-1:0]         inh_cnt;
        logic [hbomc_pkg::TICK_W-1:0]         alive_cnt;
        logic                                 alive_run;
    } st_t;

    logic [hbomc_pkg::TICK_W-1:0] inhibit_ticks_reg;
    logic [hbomc_pkg::TICK_W-1:0] alive_ticks_reg;
    logic                         stop_inhibit_reg;

    logic           in_valid_reg;
    hbomc_pkg::in_t in_reg;
    logic           out_valid_reg;
    hbomc_pkg::out_t out_reg;
    st_t            st_reg;
    st_t            st_next;
    logic           advance;

    function automatic st_t output_off(st_t s);
        st_t r;
        r = s;
        r.pwm_one   = '0;
        r.pwm_two   = '0;
        r.fwd       = 1'b0;
        r.rvs       = 1'b0;
        r.ext       = 1'b0;
        r.duty      = '0;
        r.alive_run = 1'b0;
        r.alive_cnt = '0;
        return r;
    endfunction

    function automatic st_t stop_output(st_t s, logic fault_in, logic to_inhibit,
                                        logic [hbomc_pkg::TICK_W-1:0] inh_load);
        st_t r;
        r = s;
        if (s.mode == hbomc_pkg::MODE_ON)
        begin
            r = output_off(s);
            if (to_inhibit)
            begin
                r.mode    = hbomc_pkg::MODE_INHIBIT;
                r.inh_cnt = inh_load;
            end
            else
            begin
                r.mode = hbomc_pkg::MODE_OFF;
            end
        end
        else if (s.mode == hbomc_pkg::MODE_FAULT && !fault_in)
        begin
            r.mode = hbomc_pkg::MODE_OFF;
            r.oc   = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [1:0] mode_code(hbomc_pkg::mode_t m);
        logic [1:0] c;
        unique case (m)
            hbomc_pkg::MODE_OFF:     c = hbomc_pkg::CODE_OFF;
            hbomc_pkg::MODE_ON:      c = hbomc_pkg::CODE_ON;
            hbomc_pkg::MODE_INHIBIT: c = hbomc_pkg::CODE_INHIBIT;
            hbomc_pkg::MODE_FAULT:   c = hbomc_pkg::CODE_FAULT;
            default:                 c = hbomc_pkg::CODE_OFF;
        endcase
        return c;
    endfunction

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        st_t                            s;
        logic [hbomc_pkg::TICK_W-1:0]   inh_load;
        logic [hbomc_pkg::TICK_W-1:0]   alive_lim;
        logic [hbomc_pkg::TICK_W-1:0]   alive_inc;
        logic [hbomc_pkg::CALC_W-1:0]   duty_ext;
        logic [hbomc_pkg::CALC_W-1:0]   level;
        logic [1:0]                     dir;

        s         = st_reg;
        inh_load  = (inhibit_ticks_reg == '0) ? hbomc_pkg::TICK_W'(1) : inhibit_ticks_reg;
        alive_lim = (alive_ticks_reg == '0) ? hbomc_pkg::TICK_W'(1) : alive_ticks_reg;
        alive_inc = st_reg.alive_cnt + hbomc_pkg::TICK_W'(1);
        dir       = in_reg.cmd_high[7:6];
        duty_ext  = {1'b0, in_reg.cmd_high[5:0], in_reg.cmd_low};

        if (duty_ext > hbomc_pkg::FULL_SCALE)
        begin
            level = hbomc_pkg::LEVEL_MAX;
        end
        else
        begin
            level = hbomc_pkg::FULL_SCALE - duty_ext;
        end
        if (level > hbomc_pkg::LEVEL_MAX)
        begin
            level = hbomc_pkg::LEVEL_MAX;
        end

        if (in_reg.action == hbomc_pkg::ACTION_COMMAND)
        begin
            s.alive_run = 1'b1;
            s.alive_cnt = '0;
            if (dir != 2'b00)
            begin
                if (s.mode == hbomc_pkg::MODE_OFF)
                begin
                    s.mode    = hbomc_pkg::MODE_ON;
                    s.ext     = 1'b1;
                    s.pwm_one = hbomc_pkg::LEVEL_W'(hbomc_pkg::FULL_SCALE);
                    s.pwm_two = hbomc_pkg::LEVEL_W'(hbomc_pkg::FULL_SCALE);
                    if (dir[0])
                    begin
                        s.fwd = 1'b1;
                    end
                    else
                    begin
                        s.rvs = 1'b1;
                    end
                end
                if (s.mode == hbomc_pkg::MODE_ON)
                begin
                    s.duty = duty_ext[hbomc_pkg::DUTY_W-1:0];
                    if (s.fwd)
                    begin
                        s.pwm_two = level[hbomc_pkg::LEVEL_W-1:0];
                    end
                    else if (s.rvs)
                    begin
                        s.pwm_one = level[hbomc_pkg::LEVEL_W-1:0];
                    end
                end
            end
            else if (s.mode != hbomc_pkg::MODE_OFF)
            begin
                s = stop_output(s, in_reg.fault_active, stop_inhibit_reg, inh_load);
            end
        end
        else
        begin
            if (in_reg.fault_active && !s.oc)
            begin
                s      = output_off(s);
                s.mode = hbomc_pkg::MODE_FAULT;
                s.oc   = 1'b1;
            end
            if (s.inh_cnt != '0)
            begin
                s.inh_cnt = s.inh_cnt - hbomc_pkg::TICK_W'(1);
                if (s.inh_cnt == '0 && s.mode == hbomc_pkg::MODE_INHIBIT)
                begin
                    s.mode = hbomc_pkg::MODE_OFF;
                end
            end
            // The alive counter only advances if the fault path left it running.
            if (s.alive_run)
            begin
                s.alive_cnt = alive_inc;
                if (alive_inc >= alive_lim)
                begin
                    s.alive_cnt = '0;
                    if (s.mode == hbomc_pkg::MODE_ON)
                    begin
                        s = stop_output(s, in_reg.fault_active, stop_inhibit_reg, inh_load);
                    end
                end
            end
        end
        st_next = s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inhibit_ticks_reg <= hbomc_pkg::INHIBIT_TICKS_RST;
            alive_ticks_reg   <= hbomc_pkg::ALIVE_TICKS_RST;
            stop_inhibit_reg  <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hbomc_pkg::CFG_INHIBIT_TICKS:       inhibit_ticks_reg <= cfg_data;
                hbomc_pkg::CFG_ALIVE_TICKS:         alive_ticks_reg   <= cfg_data;
                hbomc_pkg::CFG_STOP_ENTERS_INHIBIT: stop_inhibit_reg  <= cfg_data[0];
                default:                            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{mode: hbomc_pkg::MODE_OFF, default: '0};
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            out_reg.mode_now          <= mode_code(st_next.mode);
            out_reg.dir_forward       <= st_next.fwd;
            out_reg.dir_reverse       <= st_next.rvs;
            out_reg.external_control  <= st_next.ext;
            out_reg.over_current_flag <= st_next.oc;
            out_reg.duty_setting      <= st_next.duty;
            out_reg.pwm_one_level     <= st_next.pwm_one;
            out_reg.pwm_two_level     <= st_next.pwm_two;
        end
    end

endmodule

// ===== hdl/hbomc_checker.sv =====
module hbomc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input hbomc_pkg::out_t out_data
);

    // A stalled result must stay put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // Off always means the bridge is fully released.
    a_off_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.mode_now == hbomc_pkg::CODE_OFF |->
            out_data.duty_setting == '0 && !out_data.external_control &&
            out_data.pwm_one_level == '0 && out_data.pwm_two_level == '0)
        else $error("off mode with output still driven");

    // Running output has exactly one latched direction under remote control.
    a_on_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.mode_now == hbomc_pkg::CODE_ON |->
            out_data.external_control && (out_data.dir_forward != out_data.dir_reverse))
        else $error("on mode without a single direction");

    a_fault_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.mode_now == hbomc_pkg::CODE_FAULT |->
            out_data.over_current_flag)
        else $error("fault mode without over-current flag");

endmodule

bind hbridge_output_mode_controller_unit hbomc_checker u_hbomc_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] FWD_BIT = 8'h40;
    localparam logic [7:0] RVS_BIT = 8'h80;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    hbomc_pkg::in_t  in_data = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    hbomc_pkg::out_t out_data;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [1:0]      cfg_index = '0;
    logic [15:0]     cfg_data = '0;

    hbridge_output_mode_controller_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bridge state as the predictor sees it.
    hbomc_pkg::mode_t                bridge_mode;
    logic                            fwd_dir;
    logic                            rev_dir;
    logic                            remote_drive;
    logic                            oc_seen;
    logic [hbomc_pkg::DUTY_W-1:0]    duty_val;
    logic [hbomc_pkg::LEVEL_W-1:0]   level_one;
    logic [hbomc_pkg::LEVEL_W-1:0]   level_two;
    logic [hbomc_pkg::TICK_W-1:0]    inhibit_left;
    logic [hbomc_pkg::TICK_W-1:0]    alive_cnt;
    logic                            alive_on;
    logic [hbomc_pkg::TICK_W-1:0]    cfg_inhibit;
    logic [hbomc_pkg::TICK_W-1:0]    cfg_alive;
    logic                            cfg_stop_inhibit;

    hbomc_pkg::in_t  pending_items[$];
    hbomc_pkg::out_t expected_status[$];

    int accepted_items = 0;
    int offered_items = 0;
    int results_seen = 0;
    int results_paced = 0;
    int error_count = 0;
    int send_wait = 0;
    int recv_wait = 0;
    bit sender_burst = 1'b0;
    bit recv_burst = 1'b0;
    bit drain_hold = 1'b0;
    bit taken;

    task automatic report_error(input string what);
        error_count++;
        if (error_count <= 100)
            $display("%t  mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s = %0d, expected %0d",
                                   results_seen, name, got, want));
    endtask

    task automatic drop_output();
        level_one = '0;
        level_two = '0;
        fwd_dir = 1'b0;
        rev_dir = 1'b0;
        remote_drive = 1'b0;
        duty_val = '0;
        alive_on = 1'b0;
        alive_cnt = '0;
    endtask

    task automatic stop_bridge(input logic fault_level);
        if (bridge_mode == hbomc_pkg::MODE_ON)
        begin
            drop_output();
            if (cfg_stop_inhibit)
            begin
                bridge_mode = hbomc_pkg::MODE_INHIBIT;
                inhibit_left = (cfg_inhibit == '0) ? hbomc_pkg::TICK_W'(1) : cfg_inhibit;
            end
            else
                bridge_mode = hbomc_pkg::MODE_OFF;
        end
        else if (bridge_mode == hbomc_pkg::MODE_FAULT && !fault_level)
        begin
            bridge_mode = hbomc_pkg::MODE_OFF;
            oc_seen = 1'b0;
        end
    endtask

    // Works out the state after one transaction and queues the status it yields.
    task automatic advance_bridge(input hbomc_pkg::in_t item);
        logic [hbomc_pkg::DUTY_W-1:0] duty;
        logic [hbomc_pkg::CALC_W-1:0] level_val;
        logic [hbomc_pkg::TICK_W-1:0] alive_lim;
        hbomc_pkg::out_t              status;
        if (item.action == hbomc_pkg::ACTION_COMMAND)
        begin
            alive_on = 1'b1;
            alive_cnt = '0;
            if (item.cmd_high[7:6] != 2'b00)
            begin
                if (bridge_mode == hbomc_pkg::MODE_OFF)
                begin
                    bridge_mode = hbomc_pkg::MODE_ON;
                    remote_drive = 1'b1;
                    level_one = hbomc_pkg::LEVEL_W'(hbomc_pkg::FULL_SCALE);
                    level_two = hbomc_pkg::LEVEL_W'(hbomc_pkg::FULL_SCALE);
                    if (item.cmd_high[6])
                        fwd_dir = 1'b1;
                    else
                        rev_dir = 1'b1;
                end
                if (bridge_mode == hbomc_pkg::MODE_ON)
                begin
                    duty = {item.cmd_high[5:0], item.cmd_low};
                    duty_val = duty;
                    level_val = (hbomc_pkg::CALC_W'(duty) > hbomc_pkg::FULL_SCALE)
                                ? hbomc_pkg::LEVEL_MAX
                                : hbomc_pkg::FULL_SCALE - hbomc_pkg::CALC_W'(duty);
                    if (level_val > hbomc_pkg::LEVEL_MAX)
                        level_val = hbomc_pkg::LEVEL_MAX;
                    if (fwd_dir)
                        level_two = hbomc_pkg::LEVEL_W'(level_val);
                    else if (rev_dir)
                        level_one = hbomc_pkg::LEVEL_W'(level_val);
                end
            end
            else if (bridge_mode != hbomc_pkg::MODE_OFF)
                stop_bridge(item.fault_active);
        end
        else
        begin
            if (item.fault_active && !oc_seen)
            begin
                drop_output();
                bridge_mode = hbomc_pkg::MODE_FAULT;
                oc_seen = 1'b1;
            end
            if (inhibit_left != '0)
            begin
                inhibit_left = inhibit_left - hbomc_pkg::TICK_W'(1);
                if (inhibit_left == '0 && bridge_mode == hbomc_pkg::MODE_INHIBIT)
                    bridge_mode = hbomc_pkg::MODE_OFF;
            end
            if (alive_on)
            begin
                alive_lim = (cfg_alive == '0) ? hbomc_pkg::TICK_W'(1) : cfg_alive;
                alive_cnt = alive_cnt + hbomc_pkg::TICK_W'(1);
                if (alive_cnt >= alive_lim)
                begin
                    alive_cnt = '0;
                    if (bridge_mode == hbomc_pkg::MODE_ON)
                        stop_bridge(item.fault_active);
                end
            end
        end
        case (bridge_mode)
            hbomc_pkg::MODE_ON:      status.mode_now = hbomc_pkg::CODE_ON;
            hbomc_pkg::MODE_INHIBIT: status.mode_now = hbomc_pkg::CODE_INHIBIT;
            hbomc_pkg::MODE_FAULT:   status.mode_now = hbomc_pkg::CODE_FAULT;
            default:                 status.mode_now = hbomc_pkg::CODE_OFF;
        endcase
        status.dir_forward = fwd_dir;
        status.dir_reverse = rev_dir;
        status.external_control = remote_drive;
        status.over_current_flag = oc_seen;
        status.duty_setting = duty_val;
        status.pwm_one_level = level_one;
        status.pwm_two_level = level_two;
        expected_status.push_back(status);
    endtask

    function automatic hbomc_pkg::in_t make_tick(input logic fault);
        hbomc_pkg::in_t item;
        item.action = hbomc_pkg::ACTION_TICK;
        item.cmd_low = 8'($urandom);
        item.cmd_high = 8'($urandom);
        item.fault_active = fault;
        return item;
    endfunction

    function automatic hbomc_pkg::in_t make_command(input logic [7:0] high,
                                                    input logic [7:0] low,
                                                    input logic fault);
        hbomc_pkg::in_t item;
        item.action = hbomc_pkg::ACTION_COMMAND;
        item.cmd_high = high;
        item.cmd_low = low;
        item.fault_active = fault;
        return item;
    endfunction

    // Duties lean toward the edges of the level calculation.
    function automatic hbomc_pkg::in_t duty_command(input logic [1:0] dir, input logic fault);
        logic [hbomc_pkg::DUTY_W-1:0] duty;
        case ($urandom_range(0, 7))
            0:       duty = '0;
            1:       duty = hbomc_pkg::DUTY_W'(4095);
            2:       duty = hbomc_pkg::DUTY_W'(hbomc_pkg::FULL_SCALE);
            3:       duty = hbomc_pkg::DUTY_W'(4097);
            4:       duty = '1;
            5:       duty = hbomc_pkg::DUTY_W'($urandom_range(4097, 16383));
            default: duty = hbomc_pkg::DUTY_W'($urandom_range(0, 4096));
        endcase
        return make_command({dir, duty[13:8]}, duty[7:0], fault);
    endfunction

    task automatic queue_random_phase(input int count, input int run_max);
        int made;
        int kind;
        int run_len;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 4)
            begin
                pending_items.push_back(duty_command(2'($urandom_range(1, 3)),
                                                     $urandom_range(0, 15) == 0));
                made++;
            end
            else if (kind <= 7)
            begin
                // Runs of ticks let the inhibit and alive timers expire.
                run_len = $urandom_range(1, run_max);
                repeat (run_len)
                    pending_items.push_back(make_tick($urandom_range(0, 49) == 0));
                made += run_len;
            end
            else if (kind == 8)
            begin
                pending_items.push_back(make_command({2'b00, 6'($urandom)}, 8'($urandom),
                                                     1'($urandom)));
                made++;
            end
            else
            begin
                pending_items.push_back(make_tick(1'b1));
                pending_items.push_back(make_command({2'b00, 6'($urandom)}, 8'($urandom),
                                                     1'b0));
                made += 2;
            end
        end
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            hbomc_pkg::CFG_INHIBIT_TICKS:       cfg_inhibit = value;
            hbomc_pkg::CFG_ALIVE_TICKS:         cfg_alive = value;
            hbomc_pkg::CFG_STOP_ENTERS_INHIBIT: cfg_stop_inhibit = value[0];
            default:                            ;
        endcase
    endtask

    task automatic configure_bridge(input logic [15:0] inhibit_val,
                                    input logic [15:0] alive_val, input logic stop_val);
        write_register(hbomc_pkg::CFG_INHIBIT_TICKS, inhibit_val);
        write_register(hbomc_pkg::CFG_ALIVE_TICKS, alive_val);
        write_register(hbomc_pkg::CFG_STOP_ENTERS_INHIBIT, {15'd0, stop_val});
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_status.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    // Result checking first, so a transaction accepted at the same edge
    // cannot be matched against its own expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_status.size() == 0)
                    report_error($sformatf("result %0d arrived with nothing expected",
                                           results_seen));
                else
                begin
                    hbomc_pkg::out_t want;
                    want = expected_status.pop_front();
                    check_field("mode_now", 16'(out_data.mode_now), 16'(want.mode_now));
                    check_field("dir_forward", 16'(out_data.dir_forward),
                                16'(want.dir_forward));
                    check_field("dir_reverse", 16'(out_data.dir_reverse),
                                16'(want.dir_reverse));
                    check_field("external_control", 16'(out_data.external_control),
                                16'(want.external_control));
                    check_field("over_current_flag", 16'(out_data.over_current_flag),
                                16'(want.over_current_flag));
                    check_field("duty_setting", 16'(out_data.duty_setting),
                                16'(want.duty_setting));
                    check_field("pwm_one_level", 16'(out_data.pwm_one_level),
                                16'(want.pwm_one_level));
                    check_field("pwm_two_level", 16'(out_data.pwm_two_level),
                                16'(want.pwm_two_level));
                end
                results_seen++;
            end
            if (in_valid && in_ready)
            begin
                advance_bridge(in_data);
                accepted_items++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            taken = in_valid && (accepted_items == offered_items);
            if (taken)
            begin
                send_wait = sender_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 39) == 0)
                    sender_burst = !sender_burst;
                // Now and then hold off until every outstanding result is back.
                if (accepted_items % 200 == 0)
                    drain_hold = 1'b1;
            end
            if (!in_valid || taken)
            begin
                if (drain_hold && expected_status.size() == 0)
                    drain_hold = 1'b0;
                if (drain_hold || send_wait > 0 || pending_items.size() == 0)
                begin
                    if (!drain_hold && send_wait > 0)
                        send_wait--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_data <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    offered_items++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (results_seen != results_paced)
            begin
                results_paced = results_seen;
                recv_wait = recv_burst ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                // A long hold-off lets the block fill up and stall its input.
                if (results_seen == 300 || $urandom_range(0, 399) == 0)
                    recv_wait = $urandom_range(40, 90);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        int inhibit_pick;
        int alive_pick;
        int stop_pick;
        int run_max;
        bridge_mode = hbomc_pkg::MODE_OFF;
        drop_output();
        oc_seen = 1'b0;
        inhibit_left = '0;
        cfg_inhibit = hbomc_pkg::INHIBIT_TICKS_RST;
        cfg_alive = hbomc_pkg::ALIVE_TICKS_RST;
        cfg_stop_inhibit = 1'b0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: stops go straight to off.
        pending_items.push_back(make_tick(1'b0));
        pending_items.push_back(make_command(8'h00, 8'h00, 1'b0));
        pending_items.push_back(make_command(FWD_BIT, 8'h00, 1'b0));
        pending_items.push_back(make_command(FWD_BIT | 8'h10, 8'h00, 1'b0));
        pending_items.push_back(make_command(FWD_BIT | 8'h10, 8'h01, 1'b0));
        pending_items.push_back(make_command(8'h7F, 8'hFF, 1'b0));
        // Running direction must not follow a later reverse request.
        pending_items.push_back(make_command(RVS_BIT | 8'h08, 8'h00, 1'b0));
        pending_items.push_back(make_command(FWD_BIT | RVS_BIT, 8'h01, 1'b0));
        pending_items.push_back(make_command(8'h00, 8'h00, 1'b1));
        pending_items.push_back(make_command(8'hFF, 8'hFF, 1'b0));
        pending_items.push_back(make_command(8'h00, 8'h00, 1'b0));
        pending_items.push_back(make_command(RVS_BIT | 8'h0F, 8'hFF, 1'b0));
        pending_items.push_back(make_tick(1'b1));
        pending_items.push_back(make_tick(1'b1));
        pending_items.push_back(make_command(FWD_BIT, 8'h10, 1'b0));
        pending_items.push_back(make_command(8'h00, 8'h00, 1'b1));
        pending_items.push_back(make_command(8'h00, 8'h00, 1'b0));
        wait_drained();

        // Short timers with stops entering inhibit.
        configure_bridge(16'd3, 16'd4, 1'b1);
        pending_items.push_back(make_command(FWD_BIT, 8'h20, 1'b0));
        pending_items.push_back(make_command(8'h00, 8'h00, 1'b0));
        pending_items.push_back(make_command(FWD_BIT, 8'h00, 1'b0));
        repeat (3)
            pending_items.push_back(make_tick(1'b0));
        pending_items.push_back(make_command(RVS_BIT, 8'h40, 1'b0));
        repeat (7)
            pending_items.push_back(make_tick(1'b0));
        pending_items.push_back(make_tick(1'b1));
        pending_items.push_back(make_command(8'h00, 8'h00, 1'b0));

        for (int phase = 0; phase < 10; phase++)
        begin
            wait_drained();
            if (phase == 0)
            begin
                inhibit_pick = 1;
                alive_pick = 1;
                stop_pick = 1;
            end
            else if (phase == 1)
            begin
                inhibit_pick = 65535;
                alive_pick = 65535;
                stop_pick = 1;
            end
            else
            begin
                inhibit_pick = $urandom_range(1, 24);
                alive_pick = $urandom_range(1, 30);
                stop_pick = $urandom_range(0, 1);
            end
            configure_bridge(16'(inhibit_pick), 16'(alive_pick), 1'(stop_pick));
            run_max = ((alive_pick < 40) ? alive_pick : 40) + 3;
            @(posedge clk);
            queue_random_phase(126, run_max);
        end

        wait_drained();
        repeat (10)
            @(posedge clk);
        if (error_count == 0 && expected_status.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
